// ===== rtl/cifr_pkg.sv =====
// package for the case-insensitive find/replace block
// holds shared constants, register codes and the case-folding function
// no dependencies
`timescale 1ns / 1ps

package cifr_pkg;

   localparam int PATTERN_MAX_DEF     = 16;
   localparam int REPLACEMENT_MAX_DEF = 16;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 5;
   localparam int CFG_ADDR_W = 3;
   localparam int CFG_DATA_W = 64;
   localparam int TEXT_MAX   = 16;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

   typedef enum logic [CFG_ADDR_W-1:0] {
      REG_PATTERN_LOW        = 3'd0,
      REG_PATTERN_HIGH       = 3'd1,
      REG_REPLACEMENT_LOW    = 3'd2,
      REG_REPLACEMENT_HIGH   = 3'd3,
      REG_PATTERN_LENGTH     = 3'd4,
      REG_REPLACEMENT_LENGTH = 3'd5
   } csr_reg_type;

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

// ===== rtl/cifr_ifs.sv =====
// valid/ready channel interfaces for the find/replace block
// depends on cifr_pkg
`timescale 1ns / 1ps

interface cifr_req_if;
   logic                          valid;
   logic                          ready;
   logic [cifr_pkg::BYTE_W-1:0]   in_byte;
   logic                          end_of_stream;

   modport source(output valid, output in_byte, output end_of_stream, input ready);
   modport sink(input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface cifr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cifr_pkg::BYTE_W-1:0]   out_byte;
   logic                          last_of_run;

   modport source(output valid, output out_byte, output last_of_run, input ready);
   modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

interface cifr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [cifr_pkg::CFG_ADDR_W-1:0]   index;
   logic [cifr_pkg::CFG_DATA_W-1:0]   data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/cifr_front.sv =====
// front end: config registers, match window and job building
// each accepted item becomes at most one job of bytes plus a count
// depends on cifr_pkg and cifr_ifs
`timescale 1ns / 1ps

module cifr_front #(
   parameter int PATTERN_MAX     = cifr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACEMENT_MAX = cifr_pkg::REPLACEMENT_MAX_DEF
) (
   input  logic clock,
   input  logic reset,
   cifr_req_if.sink req,
   cifr_csr_if.sink csr,
   input  logic queue_full,
   output logic job_push,
   output logic [((PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX)
                 * cifr_pkg::BYTE_W - 1:0] job_bytes,
   output logic [$clog2(((PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX)
                 + 1) - 1:0] job_count
);

   localparam int JOB_BYTES = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX;
   localparam int JOB_CW    = $clog2(JOB_BYTES + 1);
   localparam int FW        = $clog2(PATTERN_MAX + 1);
   localparam int BW        = cifr_pkg::BYTE_W;
   localparam int LW        = cifr_pkg::LEN_W;
   localparam int TW        = cifr_pkg::TEXT_MAX * cifr_pkg::BYTE_W;

   logic [cifr_pkg::CFG_DATA_W-1:0] pat_lo_ff, pat_hi_ff, rep_lo_ff, rep_hi_ff;
   logic [LW-1:0]                   plen_ff, rlen_ff;
   logic [FW-1:0]                   fill_ff, fill_in;
   logic [BW-1:0]                   win_ff [PATTERN_MAX];
   logic [BW-1:0]                   win_in [PATTERN_MAX];
   logic [BW-1:0]                   wnew   [PATTERN_MAX];

   logic [TW-1:0] pat_all, rep_all;
   logic [LW-1:0] pl, rl, fill_ext, fill_inc;
   logic          hit, req_fire, csr_fire;

   assign req.ready = !queue_full;
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;
   assign csr_fire  = csr.valid && csr.ready;

   assign pat_all  = {pat_hi_ff, pat_lo_ff};
   assign rep_all  = {rep_hi_ff, rep_lo_ff};
   assign pl       = (plen_ff > LW'(PATTERN_MAX))     ? LW'(PATTERN_MAX)     : plen_ff;
   assign rl       = (rlen_ff > LW'(REPLACEMENT_MAX)) ? LW'(REPLACEMENT_MAX) : rlen_ff;
   assign fill_ext = LW'(fill_ff);
   assign fill_inc = fill_ext + LW'(1);

   // window with the new item placed at the fill position
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         wnew[i] = (LW'(i) == fill_ext) ? req.in_byte : win_ff[i];
      end
   end

   always_comb begin
      hit = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if ((LW'(i) < pl) &&
             (cifr_pkg::fold_case(wnew[i]) != cifr_pkg::fold_case(pat_all[8*i +: 8]))) begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      job_bytes = '0;
      job_count = '0;
      fill_in   = fill_ff;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         win_in[i] = win_ff[i];
      end
      if (req_fire) begin
         if (pl == '0) begin
            job_bytes[BW-1:0] = req.in_byte;
            job_count         = JOB_CW'(1);
         end else if ((fill_inc >= pl) && hit) begin
            for (int j = 0; j < REPLACEMENT_MAX; j++) begin
               job_bytes[8*j +: 8] = rep_all[8*j +: 8];
            end
            job_count = JOB_CW'(rl);
            fill_in   = '0;
         end else if (req.end_of_stream) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
               job_bytes[8*j +: 8] = wnew[j];
            end
            job_count = JOB_CW'(fill_inc);
            fill_in   = '0;
         end else if (fill_inc >= pl) begin
            // miss: oldest item goes out, window slides by one
            job_bytes[BW-1:0] = wnew[0];
            job_count         = JOB_CW'(1);
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
               win_in[i] = wnew[i+1];
            end
            win_in[PATTERN_MAX-1] = wnew[PATTERN_MAX-1];
            fill_in = FW'(fill_inc - LW'(1));
         end else begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
               win_in[i] = wnew[i];
            end
            fill_in = FW'(fill_inc);
         end
      end
      if (csr_fire && (csr.index == cifr_pkg::REG_PATTERN_LENGTH)) begin
         fill_in = '0;
      end
   end

   assign job_push = req_fire && (job_count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         rep_lo_ff <= '0;
         rep_hi_ff <= '0;
         plen_ff   <= '0;
         rlen_ff   <= '0;
      end else if (csr_fire) begin
         case (cifr_pkg::csr_reg_type'(csr.index))
            cifr_pkg::REG_PATTERN_LOW: begin
               pat_lo_ff <= csr.data;
            end
            cifr_pkg::REG_PATTERN_HIGH: begin
               pat_hi_ff <= csr.data;
            end
            cifr_pkg::REG_REPLACEMENT_LOW: begin
               rep_lo_ff <= csr.data;
            end
            cifr_pkg::REG_REPLACEMENT_HIGH: begin
               rep_hi_ff <= csr.data;
            end
            cifr_pkg::REG_PATTERN_LENGTH: begin
               plen_ff <= csr.data[LW-1:0];
            end
            cifr_pkg::REG_REPLACEMENT_LENGTH: begin
               rlen_ff <= csr.data[LW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/cifr_queue.sv =====
// two-entry job queue between front and back end
// depends on cifr_pkg
`timescale 1ns / 1ps

module cifr_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int DEPTH = cifr_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/cifr_back.sv =====
// back end: walks the head job into the output register, one byte per cycle while rsp is not stalled
// depends on cifr_pkg and cifr_ifs
`timescale 1ns / 1ps

module cifr_back #(
   parameter int JOB_BYTES = cifr_pkg::TEXT_MAX
) (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  logic [JOB_BYTES*cifr_pkg::BYTE_W-1:0] head_bytes,
   input  logic [$clog2(JOB_BYTES+1)-1:0] head_count,
   output logic pop,
   cifr_rsp_if.source rsp
);

   localparam int JOB_CW = $clog2(JOB_BYTES + 1);
   localparam int IW     = (JOB_BYTES > 1) ? $clog2(JOB_BYTES) : 1;
   localparam int BW     = cifr_pkg::BYTE_W;

   logic [IW-1:0] idx_ff, idx_in;
   logic          valid_ff, valid_in;
   logic [BW-1:0] byte_ff;
   logic          last_ff;
   logic          out_free, load, is_last;

   assign out_free = !valid_ff || rsp.ready;
   assign load     = out_free && head_valid;
   assign is_last  = (JOB_CW'(idx_ff) + JOB_CW'(1)) == head_count;
   assign pop      = load && is_last;

   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (load) begin
         idx_in = idx_ff + IW'(1);
      end
      valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_bytes[idx_ff*BW +: BW];
         last_ff <= is_last;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.last_of_run = last_ff;

`ifndef SYNTHESIS
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (JOB_CW'(idx_ff) < head_count))
      else $error("byte index beyond job length");

   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == '0))
      else $error("byte index not cleared between jobs");

   a_no_empty_job: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head_count != '0))
      else $error("empty job in queue");

   a_last_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff))
      else $error("job end not marked on output");
`endif

endmodule

// ===== rtl/case_insensitive_find_replace.sv =====
// top level of the case-insensitive find/replace block
// depends on cifr_pkg, cifr_ifs, cifr_front, cifr_queue, cifr_back
//
//   channel  dir  fields                     accepted when
//   req      in   in_byte, end_of_stream     req.valid && req.ready
//   rsp      out  out_byte, last_of_run      rsp.valid && rsp.ready
//   csr      in   index, data                csr.valid && csr.ready
//
// one item per cycle enters while the job queue has room. the back end emits
// one byte per cycle while the output is not stalled; every job (one byte,
// a replacement or an end-of-stream flush) holds its queue entry until its
// last byte is loaded, and req.ready drops once both queue entries are taken.
// synchronous active-high reset clears lengths, pattern and replacement
// bytes, window fill and queue; window bytes are not reset. csr is always ready.
`timescale 1ns / 1ps

module case_insensitive_find_replace #(
   parameter int PATTERN_MAX     = cifr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACEMENT_MAX = cifr_pkg::REPLACEMENT_MAX_DEF
) (
   input logic clock,
   input logic reset,
   cifr_req_if.sink   req,
   cifr_rsp_if.source rsp,
   cifr_csr_if.sink   csr
);

   localparam int JOB_BYTES = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX;
   localparam int JOB_CW    = $clog2(JOB_BYTES + 1);
   localparam int JOB_BW    = JOB_BYTES * cifr_pkg::BYTE_W;
   localparam int JOB_W     = JOB_BW + JOB_CW;

   logic              queue_full, job_push, head_valid, pop;
   logic [JOB_BW-1:0] job_bytes;
   logic [JOB_CW-1:0] job_count;
   logic [JOB_W-1:0]  head_data;

   cifr_front #(
      .PATTERN_MAX    (PATTERN_MAX),
      .REPLACEMENT_MAX(REPLACEMENT_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr       (csr),
      .queue_full(queue_full),
      .job_push  (job_push),
      .job_bytes (job_bytes),
      .job_count (job_count)
   );

   cifr_queue #(
      .WIDTH(JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({job_count, job_bytes}),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_data (head_data)
   );

   cifr_back #(
      .JOB_BYTES(JOB_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_bytes(head_data[JOB_BW-1:0]),
      .head_count(head_data[JOB_W-1:JOB_BW]),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

// ===== tb/tb_case_insensitive_find_replace.sv =====
// testbench for the case-insensitive find/replace block: directed and random text
// streams under random source gaps and sink stalls, results checked against a local predictor
// depends on cifr_pkg, cifr_ifs and case_insensitive_find_replace
`timescale 1ns / 1ps

module tb_case_insensitive_find_replace;

   localparam int BYTE_W              = cifr_pkg::BYTE_W;
   localparam int LEN_W               = cifr_pkg::LEN_W;
   localparam int CFG_ADDR_W          = cifr_pkg::CFG_ADDR_W;
   localparam int CFG_DATA_W          = cifr_pkg::CFG_DATA_W;
   localparam int TEXT_MAX            = cifr_pkg::TEXT_MAX;
   localparam int PATTERN_MAX_DEF     = cifr_pkg::PATTERN_MAX_DEF;
   localparam int REPLACEMENT_MAX_DEF = cifr_pkg::REPLACEMENT_MAX_DEF;

   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = cifr_pkg::CHAR_UPPER_A;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = cifr_pkg::CHAR_UPPER_Z;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = cifr_pkg::CASE_OFFSET;

   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 40;
   localparam int HOLD_CYCLES   = 150;

   localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_HI = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
   } edited_byte_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_stream;
   } text_item_type;

   typedef enum logic [1:0] {PACE_FREE, PACE_COIN, PACE_THIRD, PACE_MOSTLY} pace_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cifr_req_if req_ch();
   cifr_rsp_if rsp_ch();
   cifr_csr_if csr_ch();

   case_insensitive_find_replace dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   // predictor copy of registers and window
   logic [TEXT_MAX*BYTE_W-1:0] pattern_text;
   logic [TEXT_MAX*BYTE_W-1:0] replacement_text;
   logic [LEN_W-1:0]           pattern_len_q;
   logic [LEN_W-1:0]           replacement_len_q;
   logic [BYTE_W-1:0]          window_q [TEXT_MAX];
   int                         window_count;

   edited_byte_type expected_q[$];

   int error_count;
   int items_sent;
   int bytes_checked;
   int settings_used;
   int cycle_count;

   bit req_offering;
   bit csr_offering;
   bit gaps_enabled;
   int burst_left;
   int hold_cycles_left;

   pace_mode_type pace_mode;
   int            pace_left;
   int            pace_phase;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("case_insensitive_find_replace verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_cycles_left > 0) begin
         hold_cycles_left <= hold_cycles_left - 1;
      end
   end

   // sink pacing, chosen independently of the long hold and gated by it
   always @(posedge clock) begin : sink_pacing
      logic take;
      if (pace_left == 0) begin
         pace_mode <= pace_mode_type'($urandom_range(0, 3));
         pace_left <= $urandom_range(8, 80);
      end else begin
         pace_left <= pace_left - 1;
      end
      pace_phase <= (pace_phase + 1) % 3;
      case (pace_mode)
         PACE_FREE:  take = 1'b1;
         PACE_COIN:  take = ($urandom_range(0, 1) == 1);
         PACE_THIRD: take = (pace_phase == 0);
         default:    take = ($urandom_range(0, 3) != 0);
      endcase
      rsp_ch.ready <= take && (hold_cycles_left == 0);
   end

   task automatic report_mismatch(input string what);
      if (error_count < MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   always @(posedge clock) begin : result_check
      edited_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_ch.out_byte));
         end else begin
            want = expected_q.pop_front();
            bytes_checked++;
            if (rsp_ch.out_byte !== want.out_byte) begin
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_ch.out_byte, want.out_byte));
            end
            if (rsp_ch.last_of_run !== want.last_of_run) begin
               report_mismatch($sformatf("last_of_run %b, want %b on byte %02h",
                                         rsp_ch.last_of_run, want.last_of_run,
                                         want.out_byte));
            end
         end
      end
   end

   function automatic logic [BYTE_W-1:0] fold_letter(input logic [BYTE_W-1:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic bit is_letter(input logic [BYTE_W-1:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_UPPER_A + CASE_OFFSET && c <= CHAR_UPPER_Z + CASE_OFFSET);
   endfunction

   function automatic logic [BYTE_W-1:0] flip_case(input logic [BYTE_W-1:0] c);
      if (is_letter(c) && $urandom_range(0, 1)) begin
         return c ^ CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic int capped(input logic [LEN_W-1:0] len, input int ceiling);
      return (len > ceiling) ? ceiling : int'(len);
   endfunction

   function automatic logic [TEXT_MAX*BYTE_W-1:0] pack_text(input string s);
      logic [TEXT_MAX*BYTE_W-1:0] t = '0;
      for (int i = 0; i < s.len() && i < TEXT_MAX; i++) begin
         t[i*BYTE_W +: BYTE_W] = s[i];
      end
      return t;
   endfunction

   // edited bytes caused by one accepted text byte
   task automatic predict_edit(input logic [BYTE_W-1:0] b, input logic eos);
      int                plen;
      int                rlen;
      logic              hit;
      logic [BYTE_W-1:0] produced[$];
      edited_byte_type   e;
      plen = capped(pattern_len_q, PATTERN_MAX_DEF);
      if (window_count >= TEXT_MAX) begin
         window_count = 0;
      end
      if (plen == 0) begin
         produced.push_back(b);
      end else begin
         window_q[window_count] = b;
         window_count++;
         if (window_count >= plen) begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++) begin
               if (fold_letter(window_q[i]) !=
                   fold_letter(pattern_text[i*BYTE_W +: BYTE_W])) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               rlen = capped(replacement_len_q, REPLACEMENT_MAX_DEF);
               for (int i = 0; i < rlen; i++) begin
                  produced.push_back(replacement_text[i*BYTE_W +: BYTE_W]);
               end
               window_count = 0;
            end else begin
               produced.push_back(window_q[0]);
               for (int i = 1; i < window_count; i++) begin
                  window_q[i-1] = window_q[i];
               end
               window_count--;
            end
         end
      end
      if (eos) begin
         for (int i = 0; i < window_count; i++) begin
            produced.push_back(window_q[i]);
         end
         window_count = 0;
      end
      foreach (produced[i]) begin
         e.out_byte    = produced[i];
         e.last_of_run = (i == produced.size() - 1);
         expected_q.push_back(e);
      end
   endtask

   task automatic write_reg(input logic [CFG_ADDR_W-1:0] index,
                            input logic [CFG_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      csr_offering = 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) begin
         @(posedge clock);
      end
      case (index)
         cifr_pkg::REG_PATTERN_LOW:      pattern_text[63:0] = data;
         cifr_pkg::REG_PATTERN_HIGH:     pattern_text[127:64] = data;
         cifr_pkg::REG_REPLACEMENT_LOW:  replacement_text[63:0] = data;
         cifr_pkg::REG_REPLACEMENT_HIGH: replacement_text[127:64] = data;
         cifr_pkg::REG_PATTERN_LENGTH: begin
            pattern_len_q = data[LEN_W-1:0];
            window_count  = 0;
         end
         cifr_pkg::REG_REPLACEMENT_LENGTH: replacement_len_q = data[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_idle();
      if (csr_offering) begin
         csr_ch.valid <= 1'b0;
         csr_offering = 1'b0;
      end
   endtask

   // lengths carry random upper bits that the block must drop
   task automatic configure(input logic [TEXT_MAX*BYTE_W-1:0] pattern,
                            input logic [LEN_W-1:0]           plen,
                            input logic [TEXT_MAX*BYTE_W-1:0] replacement,
                            input logic [LEN_W-1:0]           rlen,
                            input bit                         junk);
      logic [CFG_DATA_W-1:0] noise;
      write_reg(cifr_pkg::REG_PATTERN_LOW, pattern[63:0]);
      write_reg(cifr_pkg::REG_PATTERN_HIGH, pattern[127:64]);
      write_reg(cifr_pkg::REG_REPLACEMENT_LOW, replacement[63:0]);
      write_reg(cifr_pkg::REG_REPLACEMENT_HIGH, replacement[127:64]);
      noise = {$urandom, $urandom};
      write_reg(cifr_pkg::REG_PATTERN_LENGTH, {noise[CFG_DATA_W-1:LEN_W], plen});
      noise = {$urandom, $urandom};
      write_reg(cifr_pkg::REG_REPLACEMENT_LENGTH, {noise[CFG_DATA_W-1:LEN_W], rlen});
      if (junk) begin
         write_reg($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                   {$urandom, $urandom});
      end
      csr_idle();
      settings_used++;
   endtask

   task automatic send_item(input logic [BYTE_W-1:0] b, input logic eos);
      req_ch.valid         <= 1'b1;
      req_ch.in_byte       <= b;
      req_ch.end_of_stream <= eos;
      req_offering = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      predict_edit(b, eos);
      items_sent++;
      if (gaps_enabled) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_ch.valid <= 1'b0;
            req_offering = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
         end
      end
   endtask

   task automatic send_text(input string s, input bit eos_last);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], eos_last && (i == s.len() - 1));
      end
   endtask

   // stop offering, wait out all pending results, then let the block settle
   task automatic drain();
      int waited = 0;
      if (req_offering) begin
         req_ch.valid <= 1'b0;
         req_offering = 1'b0;
      end
      while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected bytes never arrived", expected_q.size()));
         expected_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_passthrough();
      send_item(8'h00, 1'b0);
      send_item(8'hff, 1'b1);
      drain();
   endtask

   task automatic test_match_and_case();
      configure(pack_text("aB"), LEN_W'(2), pack_text("X#z"), LEN_W'(3), 1'b0);
      send_text("AbaxB", 1'b1);
      drain();
   endtask

   // neighbors of the letter range must not fold
   task automatic test_fold_boundary();
      configure(pack_text("@Z["), LEN_W'(3), pack_text("!"), LEN_W'(1), 1'b0);
      send_text("`z{@z[", 1'b1);
      drain();
   endtask

   task automatic test_delete_and_partial();
      configure(pack_text("@Z["), LEN_W'(3), {$urandom, $urandom, $urandom, $urandom},
                LEN_W'(0), 1'b0);
      send_text("@z[", 1'b1);
      send_text("@Z", 1'b1);
      drain();
   endtask

   task automatic test_length_limits();
      configure('1, LEN_W'(1), {64'hffff_ffff_ffff_ffff, 64'h0123_4567_89ab_cdef},
                LEN_W'(31), 1'b0);
      send_item(8'hff, 1'b0);
      send_item(8'h00, 1'b1);
      drain();
   endtask

   task automatic test_window_discard();
      configure(pack_text("@Z["), LEN_W'(3), pack_text("!"), LEN_W'(1), 1'b0);
      send_text("@Z", 1'b0);
      drain();
      write_reg(cifr_pkg::REG_PATTERN_LENGTH, CFG_DATA_W'(3));
      csr_idle();
      send_text("[", 1'b1);
      drain();
   endtask

   task automatic test_unmapped_registers();
      write_reg(REG_UNMAPPED_LO, '1);
      write_reg(REG_UNMAPPED_HI, '1);
      csr_idle();
      send_text("@z[", 1'b1);
      drain();
   endtask

   // mostly pattern copies and prefixes in mixed case, some near-miss and raw bytes
   task automatic test_random_traffic(input int n_items, input bit with_hold,
                                      input int plen_force, input int rlen_force);
      text_item_type              stream[$];
      logic [TEXT_MAX*BYTE_W-1:0] pattern;
      logic [BYTE_W-1:0]          c;
      int                         plen_cfg;
      int                         rlen_cfg;
      int                         eff;
      int                         pick;
      int                         run;
      int                         idx;
      pick = $urandom_range(0, 99);
      if (plen_force >= 0) plen_cfg = plen_force;
      else if (pick < 5) plen_cfg = 0;
      else if (pick < 65) plen_cfg = $urandom_range(1, 4);
      else if (pick < 90) plen_cfg = $urandom_range(5, 16);
      else plen_cfg = $urandom_range(17, 31);
      pick = $urandom_range(0, 99);
      if (rlen_force >= 0) rlen_cfg = rlen_force;
      else if (pick < 15) rlen_cfg = 0;
      else if (pick < 85) rlen_cfg = $urandom_range(1, 8);
      else if (pick < 95) rlen_cfg = $urandom_range(9, 16);
      else rlen_cfg = $urandom_range(17, 31);
      for (int i = 0; i < TEXT_MAX; i++) begin
         if ($urandom_range(0, 4) != 0) c = BYTE_W'(8'h61 + $urandom_range(0, 3));
         else c = BYTE_W'($urandom_range(0, 255));
         pattern[i*BYTE_W +: BYTE_W] = flip_case(c);
      end
      configure(pattern, LEN_W'(plen_cfg), {$urandom, $urandom, $urandom, $urandom},
                LEN_W'(rlen_cfg), $urandom_range(0, 2) == 0);
      eff = (plen_cfg > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : plen_cfg;
      while (stream.size() < n_items) begin
         pick = $urandom_range(0, 99);
         if (eff == 0 || pick >= 90) begin
            stream.push_back('{BYTE_W'($urandom_range(0, 255)),
                               $urandom_range(0, 24) == 0});
         end else if (pick < 55) begin
            run = (pick < 40) ? eff : $urandom_range(1, eff);
            for (int i = 0; i < run; i++) begin
               stream.push_back('{flip_case(pattern[i*BYTE_W +: BYTE_W]),
                                  $urandom_range(0, 24) == 0});
            end
         end else begin
            idx = $urandom_range(0, eff - 1);
            stream.push_back('{flip_case(pattern[idx*BYTE_W +: BYTE_W]),
                               $urandom_range(0, 24) == 0});
         end
      end
      stream = stream[0:n_items-1];
      stream[n_items-1].end_of_stream = 1'b1;
      if (with_hold) begin
         gaps_enabled = 1'b0;
         hold_cycles_left <= HOLD_CYCLES;
      end
      foreach (stream[i]) begin
         send_item(stream[i].in_byte, stream[i].end_of_stream);
      end
      gaps_enabled = 1'b1;
      drain();
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.in_byte       = '0;
      req_ch.end_of_stream = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.data          = '0;
      pattern_text         = '0;
      replacement_text     = '0;
      pattern_len_q        = '0;
      replacement_len_q    = '0;
      window_count         = 0;
      gaps_enabled         = 1'b1;
      burst_left           = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_passthrough();
      test_match_and_case();
      test_fold_boundary();
      test_delete_and_partial();
      test_length_limits();
      test_window_discard();
      test_unmapped_registers();

      test_random_traffic(30, 1'b0, -1, -1);
      test_random_traffic(30, 1'b0, -1, -1);
      test_random_traffic(30, 1'b1, 2, 4);
      test_random_traffic(30, 1'b0, -1, -1);
      test_random_traffic(30, 1'b0, 16, 31);
      test_random_traffic(30, 1'b0, 31, 0);

      $display("covered %0d text bytes in and %0d edited bytes out over %0d register settings",
               items_sent, bytes_checked, settings_used);
      $display("%0d mismatches found", error_count);
      if (error_count == 0) begin
         $display("case_insensitive_find_replace verification clean");
      end else begin
         $display("case_insensitive_find_replace verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cifr_pkg.sv
rtl/cifr_ifs.sv
rtl/cifr_front.sv
rtl/cifr_queue.sv
rtl/cifr_back.sv
rtl/case_insensitive_find_replace.sv
tb/tb_case_insensitive_find_replace.sv
